// File: src/pdac_pkg.sv
// Shared types and constants for the PWM duty and angle capture block.
package pdac_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int ANGLE_W     = 16;

  localparam logic [ANGLE_W-1:0]     ANGLE_MAX    = 16'd35999;
  localparam logic [CFG_DATA_W-1:0]  OFFSET_RESET = 16'd14090;
  localparam logic [CFG_DATA_W-1:0]  GAIN_RESET   = 16'd48850;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_OFFSET = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_GAIN  = 8'd1;

  // How the back end forms the ratio of one edge
  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_DIV  = 2'd2
  } kind_t;

  // Live configuration seen by the back end
  typedef struct packed {
    logic [CFG_DATA_W-1:0] duty_offset;
    logic [CFG_DATA_W-1:0] angle_gain;
  } cfg_t;

endpackage

// File: src/pdac_fifo.sv
// Two-entry request queue between the edge front end and the ratio back end.
module pdac_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store a request
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: src/pdac_front.sv
// Edge front end: keeps rise and fall times and classifies each edge's ratio.
module pdac_front #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  edge_valid,
  output logic                  edge_ready,
  input  logic                  level,
  input  logic [TIME_WIDTH-1:0] timestamp,
  output logic                  req_valid,
  input  logic                  req_ready,
  output logic [TIME_WIDTH-1:0] req_num,
  output logic [TIME_WIDTH-1:0] req_den,
  output pdac_pkg::kind_t       req_kind
);
  import pdac_pkg::*;

  logic [TIME_WIDTH-1:0] rise_time;
  logic [TIME_WIDTH-1:0] prev_rise_time;
  logic [TIME_WIDTH-1:0] fall_time;
  logic [TIME_WIDTH-1:0] rise_time_next;
  logic [TIME_WIDTH-1:0] prev_rise_time_next;
  logic [TIME_WIDTH-1:0] fall_time_next;
  logic                  rise_after_fall;
  logic                  accept;

  assign edge_ready = req_ready;
  assign req_valid  = edge_valid;
  assign accept     = edge_valid && req_ready;

  // Times as they stand after this edge
  always_comb begin
    rise_time_next      = rise_time;
    prev_rise_time_next = prev_rise_time;
    fall_time_next      = fall_time;
    if (level) begin
      prev_rise_time_next = rise_time;
      rise_time_next      = timestamp;
    end else begin
      fall_time_next = timestamp;
    end
  end

  // Period, high time and ratio class
  always_comb begin
    rise_after_fall = rise_time_next > fall_time_next;
    req_den         = rise_time_next - prev_rise_time_next;
    req_num         = rise_after_fall ? (fall_time_next - prev_rise_time_next)
                                      : (fall_time_next - rise_time_next);
    if (req_den == '0) begin
      req_kind = KIND_ZERO;
    end else if (req_num < req_den) begin
      req_kind = KIND_DIV;
    end else if (req_num == req_den || rise_after_fall) begin
      req_kind = KIND_ONE;
    end else begin
      req_kind = KIND_ZERO;
    end
  end

  // Commit edge times
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time      <= '0;
      prev_rise_time <= '0;
      fall_time      <= '0;
    end else if (accept) begin
      rise_time      <= rise_time_next;
      prev_rise_time <= prev_rise_time_next;
      fall_time      <= fall_time_next;
    end
  end

endmodule

// File: src/pdac_back.sv
// Ratio back end: radix-2 fractional divide, offset and gain, range check.
module pdac_back #(
  parameter int TIME_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pdac_pkg::cfg_t               cfg,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [TIME_WIDTH-1:0]        req_num,
  input  logic [TIME_WIDTH-1:0]        req_den,
  input  pdac_pkg::kind_t              req_kind,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [FRAC_BITS:0]           duty_ratio,
  output logic [pdac_pkg::ANGLE_W-1:0] angle_centideg,
  output logic                         angle_valid
);
  import pdac_pkg::*;

  localparam int RW    = FRAC_BITS + 1;
  localparam int CW    = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;
  localparam int PW    = CW + CFG_DATA_W;
  localparam int AW    = PW - FRAC_BITS;
  localparam int CNT_W = $clog2(FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_CHK  = 4'b1000
  } state_t;

  state_t                state;
  logic [TIME_WIDTH-1:0] rem;
  logic [TIME_WIDTH-1:0] den;
  logic [FRAC_BITS-1:0]  quo;
  logic [CNT_W-1:0]      cnt;
  logic [RW-1:0]         ratio;
  logic [PW-1:0]         prod;
  logic                  above_offset;
  logic [TIME_WIDTH:0]   shifted;
  logic [TIME_WIDTH:0]   den_ext;
  logic                  take_bit;
  logic [CW-1:0]         ratio_ext;
  logic [CW-1:0]         offset_ext;
  logic [AW-1:0]         angle_full;
  logic                  in_range;

  assign req_ready = (state == S_IDLE);

  // One quotient bit per cycle
  always_comb begin
    shifted  = {rem, 1'b0};
    den_ext  = {1'b0, den};
    take_bit = (shifted >= den_ext);
  end

  // Offset and range terms
  always_comb begin
    ratio_ext  = CW'(ratio);
    offset_ext = CW'(cfg.duty_offset);
    angle_full = prod[PW-1:FRAC_BITS];
    in_range   = above_offset && (angle_full != '0) && (angle_full <= AW'(ANGLE_MAX));
  end

  // Sequence one request through divide, multiply and check
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req_valid) state <= (req_kind == KIND_DIV) ? S_DIV : S_MUL;
        S_DIV:  if (cnt == '0) state <= S_MUL;
        S_MUL:  state <= S_CHK;
        S_CHK:  if (!res_valid || res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rem <= req_num;
        den <= req_den;
        quo <= '0;
        cnt <= CNT_W'(FRAC_BITS - 1);
        ratio <= (req_kind == KIND_ONE) ? RW'(1) << FRAC_BITS : '0;
      end
      S_DIV: begin
        rem <= take_bit ? TIME_WIDTH'(shifted - den_ext) : shifted[TIME_WIDTH-1:0];
        quo <= {quo[FRAC_BITS-2:0], take_bit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          ratio <= {1'b0, quo[FRAC_BITS-2:0], take_bit};
        end
      end
      S_MUL: begin
        above_offset <= ratio_ext > offset_ext;
        prod         <= PW'(ratio_ext - offset_ext) * PW'(cfg.angle_gain);
      end
      S_CHK: ;
      default: ;
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_CHK && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHK && (!res_valid || res_ready)) begin
      duty_ratio     <= ratio;
      angle_centideg <= in_range ? angle_full[ANGLE_W-1:0] : '0;
      angle_valid    <= in_range;
    end
  end

endmodule

// File: src/pwm_duty_angle_capture.sv
// Top level of the PWM duty and angle capture block.
//
//  Channel   Signals                              Payload
//  s_*       s_tvalid s_tready s_tdata s_tuser    edge time, edge level
//  m_*       m_tvalid m_tready m_tdata m_tuser    duty ratio, angle, valid flag
//  cfg_*     cfg_valid cfg_ready cfg_index cfg_data  duty offset, angle gain
//
// In the back end an edge is loaded, then passes through the radix-2 divider,
// the offset multiply and the range check. Edges with no division skip the
// divider. A two-entry queue lets the front end take edges while the back end
// works; a stalled output holds the back end in its check step.
// Reset clears edge times, queue and control; registers return to defaults.
module pwm_duty_angle_capture #(
  parameter int TIME_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((TIME_WIDTH+7)/8)*8-1:0] s_tdata,  // timestamp
  input  logic s_tuser,                             // level
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((FRAC_BITS+17+7)/8)*8-1:0] m_tdata, // duty_ratio, angle_centideg
  output logic m_tuser,                              // angle_valid
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pdac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pdac_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pdac_pkg::*;

  localparam int OUT_W = ((FRAC_BITS + 17 + 7) / 8) * 8;
  localparam int REQ_W = 2 * TIME_WIDTH + 2;

  cfg_t                  cfg;
  logic                  fr_valid;
  logic                  fr_ready;
  logic [TIME_WIDTH-1:0] fr_num;
  logic [TIME_WIDTH-1:0] fr_den;
  kind_t                 fr_kind;
  logic [REQ_W-1:0]      q_din;
  logic [REQ_W-1:0]      q_dout;
  logic                  bk_valid;
  logic                  bk_ready;
  logic [FRAC_BITS:0]    duty_ratio;
  logic [ANGLE_W-1:0]    angle_centideg;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_offset <= OFFSET_RESET;
      cfg.angle_gain  <= GAIN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DUTY_OFFSET) begin
        cfg.duty_offset <= cfg_data;
      end else if (cfg_index == REG_ANGLE_GAIN) begin
        cfg.angle_gain <= cfg_data;
      end
    end
  end

  pdac_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .edge_valid(s_tvalid),
    .edge_ready(s_tready),
    .level     (s_tuser),
    .timestamp (s_tdata[TIME_WIDTH-1:0]),
    .req_valid (fr_valid),
    .req_ready (fr_ready),
    .req_num   (fr_num),
    .req_den   (fr_den),
    .req_kind  (fr_kind)
  );

  assign q_din = {fr_kind, fr_num, fr_den};

  pdac_fifo #(
    .WIDTH(REQ_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .in_ready (fr_ready),
    .in_data  (q_din),
    .out_valid(bk_valid),
    .out_ready(bk_ready),
    .out_data (q_dout)
  );

  pdac_back #(
    .TIME_WIDTH(TIME_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .req_valid     (bk_valid),
    .req_ready     (bk_ready),
    .req_num       (q_dout[2*TIME_WIDTH-1:TIME_WIDTH]),
    .req_den       (q_dout[TIME_WIDTH-1:0]),
    .req_kind      (kind_t'(q_dout[REQ_W-1:2*TIME_WIDTH])),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .duty_ratio    (duty_ratio),
    .angle_centideg(angle_centideg),
    .angle_valid   (m_tuser)
  );

  assign m_tdata = OUT_W'({angle_centideg, duty_ratio});

endmodule

// File: verif/pwm_duty_angle_capture_test.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the PWM duty and angle capture block.
module pwm_duty_angle_capture_test;
  import pdac_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_EDGES  = 150;
  localparam int NUM_PHASES   = 8;
  localparam logic [16:0] RATIO_ONE = 17'h10000;

  // One result as it leaves the block
  typedef struct packed {
    logic [16:0] ratio;
    logic [15:0] angle;
    logic        valid;
  } duty_result_t;

  // One directed edge, with a typed result where it is obvious
  typedef struct packed {
    logic         lvl;
    logic [31:0]  ts;
    logic         typed;
    duty_result_t res;
  } edge_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // timestamp
  logic        s_tuser;   // level
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // duty_ratio, angle_centideg
  logic        m_tuser;   // angle_valid
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Directed edges: zero period, cap at one, overrun to zero, exact one, wrap
  edge_row_t edge_table [0:17] = '{
    '{1'b0, 32'd0,        1'b1, '{17'd0,     16'd0, 1'b0}},
    '{1'b1, 32'd1000,     1'b1, '{17'd0,     16'd0, 1'b0}},
    '{1'b0, 32'd1500,     1'b0, '0},
    '{1'b1, 32'd2000,     1'b0, '0},
    '{1'b1, 32'd3000,     1'b1, '{17'h10000, 16'd0, 1'b0}},
    '{1'b0, 32'd10000,    1'b1, '{17'd0,     16'd0, 1'b0}},
    '{1'b0, 32'd4000,     1'b1, '{17'h10000, 16'd0, 1'b0}},
    '{1'b1, 32'd3000,     1'b1, '{17'd0,     16'd0, 1'b0}},
    '{1'b1, 32'hFFFFFFF0, 1'b0, '0},
    '{1'b0, 32'hFFFFFFFF, 1'b0, '0},
    '{1'b1, 32'h00000010, 1'b0, '0},
    '{1'b0, 32'h00000018, 1'b0, '0},
    '{1'b1, 32'h00000020, 1'b0, '0},
    '{1'b0, 32'h0000002F, 1'b0, '0},
    '{1'b1, 32'h7FFFFFFF, 1'b0, '0},
    '{1'b0, 32'h80000000, 1'b0, '0},
    '{1'b1, 32'hAAAAAAAA, 1'b0, '0},
    '{1'b0, 32'h55555555, 1'b0, '0}
  };

  // Predictor state
  logic [31:0] rise_t, prev_rise_t, fall_t;
  logic [15:0] cur_offset, cur_gain;
  duty_result_t duty_expect_q [$];
  int mismatch_cnt = 0;

  // Sender and edge generator state
  int          burst_left = 0;
  bit          hold_req = 1'b0;
  logic [31:0] pwm_rise_at, pwm_period, pwm_high;
  bit          pwm_want_rise;

  pwm_duty_angle_capture u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Update edge times and compute the duty ratio and angle for one edge
  function automatic duty_result_t predict_edge(input logic lvl, input logic [31:0] ts);
    duty_result_t res;
    logic [31:0] num, den;
    logic rise_late;
    longint unsigned scaled;
    res = '0;
    if (lvl) begin
      prev_rise_t = rise_t;
      rise_t = ts;
    end else begin
      fall_t = ts;
    end
    den = rise_t - prev_rise_t;
    rise_late = rise_t > fall_t;
    num = rise_late ? fall_t - prev_rise_t : fall_t - rise_t;
    if (den != 0) begin
      if (num < den) begin
        res.ratio = 17'((64'(num) << 16) / 64'(den));
      end else if (num == den || rise_late) begin
        res.ratio = RATIO_ONE;
      end
      if (res.ratio > 17'(cur_offset)) begin
        scaled = ((64'(res.ratio) - 64'(cur_offset)) * 64'(cur_gain)) >> 16;
        if (scaled >= 1 && scaled <= 64'(ANGLE_MAX)) begin
          res.angle = scaled[15:0];
          res.valid = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Pick the period and high time of the next PWM cycle
  function automatic void pick_pwm_shape();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) pwm_period = $urandom_range(1000, 20000);
    else if (r < 85) pwm_period = $urandom_range(1, 64);
    else if (r < 95) pwm_period = $urandom;
    else pwm_period = 32'd0;
    // Let the high time overrun the period now and then
    if ($urandom_range(0, 9) == 0) begin
      pwm_high = pwm_period + $urandom_range(0, 2000);
    end else begin
      pwm_high = 32'((64'(pwm_period) * 64'($urandom_range(0, 65536))) >> 16);
    end
  endfunction

  // Produce the next edge: mostly a clean PWM train, with stray edges and time jumps
  task automatic next_pwm_edge(output logic lvl, output logic [31:0] ts);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      lvl = 1'($urandom_range(0, 1));
      ts = pwm_rise_at + $urandom_range(0, 4000);
    end else if (r < 11) begin
      lvl = 1'($urandom_range(0, 1));
      ts = $urandom;
    end else begin
      if (r < 13 && pwm_want_rise) pwm_rise_at = $urandom;
      if (pwm_want_rise) begin
        lvl = 1'b1;
        ts = pwm_rise_at;
      end else begin
        lvl = 1'b0;
        ts = pwm_rise_at + pwm_high;
        pwm_rise_at = pwm_rise_at + pwm_period;
        pick_pwm_shape();
      end
      pwm_want_rise = !pwm_want_rise;
    end
  endtask

  // Offer one edge request, in bursts with random gaps
  task automatic send_edge(input logic lvl, input logic [31:0] ts, input logic typed,
                           input duty_result_t typed_res);
    int gap;
    duty_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= ts;
    s_tuser  <= lvl;
    do @(posedge clk); while (!s_tready);
    res = predict_edge(lvl, ts);
    duty_expect_q.push_back(typed ? typed_res : res);
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DUTY_OFFSET) cur_offset = val;
    else if (idx == REG_ANGLE_GAIN) cur_gain = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the back end settle
  task automatic wait_drain();
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    duty_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[16:0], m_tdata[32:17], m_tuser};
      if (duty_expect_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with nothing expected, expected none, got %0d/%0d/%0d",
                 $time, got.ratio, got.angle, got.valid);
      end else begin
        want = duty_expect_q.pop_front();
        if (got.ratio !== want.ratio)
          note_mismatch("duty_ratio", 32'(want.ratio), 32'(got.ratio));
        if (got.angle !== want.angle)
          note_mismatch("angle_centideg", 32'(want.angle), 32'(got.angle));
        if (got.valid !== want.valid)
          note_mismatch("angle_valid", 32'(want.valid), 32'(got.valid));
      end
    end
  end

  // Receiver: stall on shifting patterns, with one long hold-off on request
  initial begin
    rx_mode_t mode;
    int unsigned mode_left, hold_left, tick;
    m_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= (tick % 4 == 0);
          default:   m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Stimulus: reset, directed edges, then random phases under several settings
  initial begin
    int p, n;
    logic lvl;
    logic [31:0] ts;
    logic [15:0] off, gain;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rise_t = '0;
    prev_rise_t = '0;
    fall_t = '0;
    cur_offset = OFFSET_RESET;
    cur_gain = GAIN_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed edges at the reset settings
    for (n = 0; n < $size(edge_table); n++)
      send_edge(edge_table[n].lvl, edge_table[n].ts, edge_table[n].typed, edge_table[n].res);

    pwm_rise_at = $urandom;
    pwm_want_rise = 1'b1;
    pick_pwm_shape();

    for (p = 0; p < NUM_PHASES; p++) begin
      // Drop valid and drain before touching the registers
      @(negedge clk);
      s_tvalid <= 1'b0;
      burst_left = 0;
      wait_drain();
      case (p)
        0: begin off = OFFSET_RESET; gain = GAIN_RESET; end
        1: begin off = 16'd0;        gain = 16'hFFFF;   end
        2: begin off = 16'hFFFF;     gain = 16'hFFFF;   end
        3: begin off = 16'd0;        gain = 16'd0;      end
        4: begin off = 16'hFFFF;     gain = 16'd0;      end
        5: begin off = 16'd8000;     gain = 16'd30000;  end
        6: begin off = 16'($urandom); gain = 16'($urandom); end
        default: begin off = OFFSET_RESET; gain = GAIN_RESET; end
      endcase
      write_reg(REG_DUTY_OFFSET, off);
      write_reg(REG_ANGLE_GAIN, gain);
      // Fill the block while the receiver holds off
      if (p == 5) hold_req = 1'b1;
      for (n = 0; n < PHASE_EDGES; n++) begin
        next_pwm_edge(lvl, ts);
        send_edge(lvl, ts, 1'b0, '0);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drain();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
